### design/assert_macros.svh
// assertion macros used by the unit top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_CLK_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NR(label, clk, prop)
`endif
`endif

### design/mdu_pkg.sv
// types, constants and helpers for the multiply/divide unit
// no dependencies
package mdu_pkg;
  localparam int unsigned XLEN = 64;
  localparam int unsigned NCELL = 64;

  typedef enum logic [3:0] {
    CMD_MUL = 4'd0, CMD_MULH = 4'd1, CMD_MULHSU = 4'd2, CMD_MULHU = 4'd3,
    CMD_DIV = 4'd4, CMD_DIVU = 4'd5, CMD_REM = 4'd6, CMD_REMU = 4'd7,
    CMD_MULW = 4'd8, CMD_DIVW = 4'd9, CMD_DIVUW = 4'd10, CMD_REMW = 4'd11,
    CMD_REMUW = 4'd12
  } cmd_t;

  // flags carried down the chain with each word
  typedef struct packed {
    logic is_mul;   // multiply: accumulate, else restoring division step
    logic hi;       // take upper half of product
    logic word;     // 32-bit form, sign-extend result
    logic rem;      // want remainder
    logic neg_res;  // negate final value
    logic special;  // result fixed at entry
    logic valid;
  } ctl_t;

  // per-cell working state
  typedef struct packed {
    ctl_t ctl;
    logic [XLEN-1:0] a;    // multiplier / dividend shifting in
    logic [XLEN-1:0] b;    // multiplicand / divisor
    logic [XLEN-1:0] acc;  // product high part / partial remainder
    logic [XLEN-1:0] aux;  // product low part / quotient / special result
  } slot_t;

  function automatic logic [XLEN-1:0] sx32(input logic [XLEN-1:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction
endpackage

### design/mdu_if.sv
// valid/ready channel interfaces for the multiply/divide unit
// depends on mdu_pkg
interface mdu_in_if;
  import mdu_pkg::*;
  logic valid;
  logic ready;
  logic [3:0] cmd;
  logic [XLEN-1:0] operand_a;
  logic [XLEN-1:0] operand_b;
  modport source (output valid, cmd, operand_a, operand_b, input ready);
  modport sink (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface mdu_out_if;
  import mdu_pkg::*;
  logic valid;
  logic ready;
  logic [XLEN-1:0] result;
  modport source (output valid, result, input ready);
  modport sink (input valid, result, output ready);
endinterface

### design/mdu_cell.sv
// one step cell: one bit of shift-add multiply or restoring divide
// depends on mdu_pkg
module mdu_cell import mdu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  slot_t din,
  output slot_t dout
);
  slot_t nxt;
  logic [XLEN:0] sum;
  logic [XLEN:0] rem_sh;
  logic [XLEN:0] diff;

  always_comb begin
    nxt = din;
    sum = '0;
    rem_sh = '0;
    diff = '0;
    if (din.ctl.valid && !din.ctl.special) begin
      if (din.ctl.is_mul) begin
        // lsb of a selects add; {acc,aux} shifts right
        sum = {1'b0, din.acc} + (din.a[0] ? {1'b0, din.b} : '0);
        nxt.acc = sum[XLEN:1];
        nxt.aux = {sum[0], din.aux[XLEN-1:1]};
        nxt.a = {1'b0, din.a[XLEN-1:1]};
      end else begin
        rem_sh = {din.acc, din.a[XLEN-1]};
        diff = rem_sh - {1'b0, din.b};
        nxt.a = {din.a[XLEN-2:0], 1'b0};
        if (!diff[XLEN]) begin
          nxt.acc = diff[XLEN-1:0];
          nxt.aux = {din.aux[XLEN-2:0], 1'b1};
        end else begin
          nxt.acc = rem_sh[XLEN-1:0];
          nxt.aux = {din.aux[XLEN-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.ctl <= '0;
    end else if (en) begin
      dout.ctl <= nxt.ctl;
    end
    if (en) begin
      dout.a <= nxt.a;
      dout.b <= nxt.b;
      dout.acc <= nxt.acc;
      dout.aux <= nxt.aux;
    end
  end
endmodule

### design/mdu_front.sv
// entry stage: operand conditioning, special cases, sign handling
// depends on mdu_pkg
module mdu_front import mdu_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [3:0]      cmd,
  input  logic [XLEN-1:0] operand_a,
  input  logic [XLEN-1:0] operand_b,
  output slot_t           dout
);
  slot_t s;
  logic [XLEN-1:0] a, b, ma, mb;
  logic sa, sb, na, nb, sgn, mul, div, w, rm, hi;

  always_comb begin
    s = '0;
    mul = 1'b0; div = 1'b0; w = 1'b0; rm = 1'b0; hi = 1'b0;
    sa = 1'b0; sb = 1'b0;
    case (cmd_t'(cmd))
      CMD_MUL:    mul = 1'b1;
      CMD_MULH:   begin mul = 1'b1; hi = 1'b1; sa = 1'b1; sb = 1'b1; end
      CMD_MULHSU: begin mul = 1'b1; hi = 1'b1; sa = 1'b1; end
      CMD_MULHU:  begin mul = 1'b1; hi = 1'b1; end
      CMD_DIV:    begin div = 1'b1; sa = 1'b1; sb = 1'b1; end
      CMD_DIVU:   div = 1'b1;
      CMD_REM:    begin div = 1'b1; rm = 1'b1; sa = 1'b1; sb = 1'b1; end
      CMD_REMU:   begin div = 1'b1; rm = 1'b1; end
      CMD_MULW:   begin mul = 1'b1; w = 1'b1; end
      CMD_DIVW:   begin div = 1'b1; w = 1'b1; sa = 1'b1; sb = 1'b1; end
      CMD_DIVUW:  begin div = 1'b1; w = 1'b1; end
      CMD_REMW:   begin div = 1'b1; w = 1'b1; rm = 1'b1; sa = 1'b1; sb = 1'b1; end
      CMD_REMUW:  begin div = 1'b1; w = 1'b1; rm = 1'b1; end
      default: ;
    endcase
    // word forms: extend low halves by signedness
    a = w ? (sa ? sx32(operand_a) : {32'd0, operand_a[31:0]}) : operand_a;
    b = w ? (sb ? sx32(operand_b) : {32'd0, operand_b[31:0]}) : operand_b;
    na = sa & a[XLEN-1];
    nb = sb & b[XLEN-1];
    ma = na ? -a : a;
    mb = nb ? -b : b;
    sgn = rm ? na : (na ^ nb);
    s.ctl.valid = in_valid;
    s.ctl.is_mul = mul;
    s.ctl.hi = hi;
    s.ctl.word = w;
    s.ctl.rem = rm;
    s.ctl.neg_res = mul ? (na ^ nb) : sgn;
    s.a = ma;
    s.b = mb;
    if (!mul && !div) begin
      s.ctl.special = 1'b1;
      s.aux = '0;
    end else if (div && b == '0) begin
      s.ctl.special = 1'b1;
      s.aux = rm ? a : '1;
    end else if (div && sa && sb && b == '1 &&
                 a == (w ? sx32(64'h8000_0000) : {1'b1, {(XLEN-1){1'b0}}})) begin
      s.ctl.special = 1'b1;
      s.aux = rm ? '0 : a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.ctl <= '0;
    end else if (en) begin
      dout.ctl <= s.ctl;
    end
    if (en) begin
      dout.a <= s.a;
      dout.b <= s.b;
      dout.acc <= s.acc;
      dout.aux <= s.aux;
    end
  end
endmodule

### design/rv64m_multiply_divide_unit_core.sv
// multiply/divide unit top level: entry stage, chain of 64 step cells, exit stage
// depends on mdu_pkg, mdu_if, mdu_cell, mdu_front, assert_macros.svh
`include "assert_macros.svh"
// Fully pipelined RV64M unit. A word enters in every cycle that the output
// side is not stalled and passes through one entry stage, 64 step cells and
// one exit stage; each cell does one bit of shift-add multiply or restoring
// divide. Operands enter as magnitudes; the sign is restored at the exit,
// where the 32-bit forms are sign-extended. Divide by zero and signed
// overflow are resolved at entry and carried through unchanged. Unused
// command codes give zero. The whole chain advances together, so a stalled
// result holds every stage.
module rv64m_multiply_divide_unit_core import mdu_pkg::*; (
  input logic clk,
  input logic rst,
  mdu_in_if.sink in,
  mdu_out_if.source out
);
  slot_t chain [NCELL+1];
  logic en;
  logic [XLEN-1:0] raw, val;
  logic [XLEN-1:0] res;
  logic res_valid;

  // advance whenever the exit register is free or being drained
  assign en = !res_valid || out.ready;
  assign in.ready = en;

  mdu_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in.valid), .cmd(in.cmd),
    .operand_a(in.operand_a), .operand_b(in.operand_b), .dout(chain[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    mdu_cell u_cell (.clk(clk), .rst(rst), .en(en), .din(chain[i]), .dout(chain[i+1]));
  end

  // finish: pick half or quotient/remainder, fix sign, extend word forms
  always_comb begin
    slot_t t;
    t = chain[NCELL];
    if (t.ctl.special) begin
      raw = t.aux;
    end else begin
      if (t.ctl.is_mul) begin
        // signed high half: negate 128-bit product
        if (t.ctl.hi) raw = t.ctl.neg_res ? (~t.acc + {63'd0, (t.aux == '0)}) : t.acc;
        else raw = t.ctl.neg_res ? -t.aux : t.aux;
      end else begin
        raw = t.ctl.rem ? t.acc : t.aux;
        if (t.ctl.neg_res) raw = -raw;
      end
    end
    // word forms, fixed results included, extend from bit 31
    val = t.ctl.word ? sx32(raw) : raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= chain[NCELL].ctl.valid;
    end
    if (en) begin
      res <= val;
    end
  end

  assign out.valid = res_valid;
  assign out.result = res;

  // a stalled result holds while the chain is frozen
  `ASSERT_CLK(a_hold, clk, rst, (out.valid && !out.ready) |=> (out.valid && $stable(out.result)))
  // no input taken while the exit stalls
  `ASSERT_CLK(a_stall, clk, rst, (out.valid && !out.ready) |-> !in.ready)
  // the exit register captures the last cell's valid whenever the chain advances
  `ASSERT_CLK(a_exit, clk, rst, en |=> (out.valid == $past(chain[NCELL].ctl.valid)))
endmodule

### dv/mdu_checker.sv
// result checker for the multiply/divide unit: predicts each result and compares
// depends on mdu_pkg and mdu_if
`timescale 1ns / 100ps
module mdu_checker import mdu_pkg::*; (
  input logic clk,
  input logic rst,
  mdu_in_if.sink in_mon,
  mdu_out_if.sink out_mon,
  output int errors,
  output int pending,
  output int results_seen
);
  logic [XLEN-1:0] expected_results[$];

  function automatic logic [XLEN-1:0] high_product(input logic [XLEN-1:0] a,
      input logic [XLEN-1:0] b, input bit a_signed, input bit b_signed);
    logic signed [2*XLEN+1:0] pa, pb, prod;
    pa = a_signed ? {{(XLEN+2){a[XLEN-1]}}, a} : {{(XLEN+2){1'b0}}, a};
    pb = b_signed ? {{(XLEN+2){b[XLEN-1]}}, b} : {{(XLEN+2){1'b0}}, b};
    prod = pa * pb;
    return prod[2*XLEN-1:XLEN];
  endfunction

  // signed divide / remainder; operands already widened to 64 bits
  function automatic logic [XLEN-1:0] signed_divrem(input logic [XLEN-1:0] a,
      input logic [XLEN-1:0] b, input bit want_rem, input logic [XLEN-1:0] most_neg);
    logic [XLEN-1:0] ma, mb, q, r;
    if (b == '0) return want_rem ? a : '1;
    if (a == most_neg && b == '1) return want_rem ? '0 : a;
    ma = a[XLEN-1] ? -a : a;
    mb = b[XLEN-1] ? -b : b;
    q = ma / mb;
    r = ma % mb;
    if (want_rem) return a[XLEN-1] ? -r : r;
    return (a[XLEN-1] != b[XLEN-1]) ? -q : q;
  endfunction

  function automatic logic [XLEN-1:0] unsigned_divrem(input logic [XLEN-1:0] a,
      input logic [XLEN-1:0] b, input bit want_rem);
    if (b == '0) return want_rem ? a : '1;
    return want_rem ? a % b : a / b;
  endfunction

  // sign-extend the low 32 bits
  function automatic logic [XLEN-1:0] widen(input logic [XLEN-1:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic [XLEN-1:0] predict_result(input logic [3:0] op,
      input logic [XLEN-1:0] a, input logic [XLEN-1:0] b);
    logic [XLEN-1:0] as32, bs32, au32, bu32, low_prod;
    as32 = widen(a);
    bs32 = widen(b);
    au32 = {32'd0, a[31:0]};
    bu32 = {32'd0, b[31:0]};
    low_prod = a * b;
    case (op)
      CMD_MUL:    return low_prod;
      CMD_MULH:   return high_product(a, b, 1'b1, 1'b1);
      CMD_MULHSU: return high_product(a, b, 1'b1, 1'b0);
      CMD_MULHU:  return high_product(a, b, 1'b0, 1'b0);
      CMD_DIV:    return signed_divrem(a, b, 1'b0, 64'h8000_0000_0000_0000);
      CMD_DIVU:   return unsigned_divrem(a, b, 1'b0);
      CMD_REM:    return signed_divrem(a, b, 1'b1, 64'h8000_0000_0000_0000);
      CMD_REMU:   return unsigned_divrem(a, b, 1'b1);
      CMD_MULW:   return widen(low_prod);
      CMD_DIVW:   return widen(signed_divrem(as32, bs32, 1'b0, widen(64'h8000_0000)));
      CMD_DIVUW:  return widen(unsigned_divrem(au32, bu32, 1'b0));
      CMD_REMW:   return widen(signed_divrem(as32, bs32, 1'b1, widen(64'h8000_0000)));
      CMD_REMUW:  return widen(unsigned_divrem(au32, bu32, 1'b1));
      default:    return '0;
    endcase
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    if (rst) begin
      errors <= 0;
      results_seen <= 0;
      expected_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(predict_result(in_mon.cmd, in_mon.operand_a,
                                                  in_mon.operand_b));
      if (out_mon.valid && out_mon.ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $error("unexpected result word %h", out_mon.result);
          errors <= errors + 1;
        end else if (expected_results[0] !== out_mon.result) begin
          $error("result: expected %h, actual %h", expected_results[0], out_mon.result);
          errors <= errors + 1;
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
    end
  end
endmodule

### dv/rv64m_multiply_divide_unit_core_test.sv
// top of the multiply/divide unit testbench: clock, reset, stimulus and verdict
// depends on mdu_pkg, mdu_if, mdu_checker and the unit itself
`timescale 1ns / 100ps
module rv64m_multiply_divide_unit_core_test;
  import mdu_pkg::*;

  localparam int PIPE_LATENCY = 66;
  localparam int RANDOM_WORDS = 930;
  localparam int STALL_LIMIT = 5000;

  logic clk = 0;
  logic rst = 1;
  int errors, pending, results_seen;
  int idle_cycles = 0;
  int words_sent = 0;
  bit stim_done = 0;
  bit hold_off = 0;

  mdu_in_if in_ch();
  mdu_out_if out_ch();

  always #2 clk = ~clk;

  rv64m_multiply_divide_unit_core u_dut (
    .clk(clk), .rst(rst), .in(in_ch.sink), .out(out_ch.source)
  );

  mdu_checker u_checker (
    .clk(clk), .rst(rst), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    in_ch.valid = 0;
    in_ch.cmd = CMD_MUL;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready = 0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // operand values weighted towards the awkward corners
  function automatic logic [XLEN-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7fff_ffff_ffff_ffff;
      4: return {{32{$urandom_range(0, 1) == 1}}, 32'h8000_0000};
      5: return 64'($urandom_range(0, 15));
      6: return {32'd0, 32'($urandom)};
      7: return {$urandom, $urandom} >> $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // offer one word and hold it until the unit takes it
  task automatic send_word(input logic [3:0] op, input logic [XLEN-1:0] a,
                           input logic [XLEN-1:0] b);
    in_ch.valid <= 1;
    in_ch.cmd <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic pause_sender();
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver: random stalls, with one long hold-off while the sender keeps going
  initial begin
    int gap;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
      if (gap > 0) begin
        out_ch.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
    end
  end

  // watchdog on cycles with no word accepted on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (!rst && !(stim_done && pending == 0))
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[rv64m_multiply_divide_unit_core] ERROR");
      $finish;
    end
  end

  initial begin
    logic [XLEN-1:0] corners[6];
    int n;
    corners = '{64'd0, 64'd1, '1, 64'h8000_0000_0000_0000,
                64'h7fff_ffff_ffff_ffff, 64'hffff_ffff_8000_0000};
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // every command, including the unused codes, on corner operands
    for (int op = 0; op < 16; op++)
      send_word(4'(op), corners[op % 6], corners[(op + 3) % 6]);
    // divide by zero and signed overflow at both widths, then MULH and MULHSU of all ones
    send_word(CMD_DIV, 64'h8000_0000_0000_0000, '1);
    send_word(CMD_REM, 64'h8000_0000_0000_0000, '1);
    send_word(CMD_DIVW, 64'h1234_5678_8000_0000, 64'h0000_0000_ffff_ffff);
    send_word(CMD_REMW, 64'h8000_0000, 64'hffff_ffff);
    send_word(CMD_DIVU, '1, '0);
    send_word(CMD_REMUW, 64'hdead_beef_cafe_f00d, 64'hffff_ffff_0000_0000);
    send_word(CMD_MULH, '1, '1);
    send_word(CMD_MULHSU, '1, '1);

    // random part; partway through the receiver holds off for a long time
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 3) hold_off = 1;
      if ($urandom_range(0, 2) != 0) pause_sender();
      send_word(($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                             : 4'($urandom_range(0, 12)),
                pick_operand(), pick_operand());
    end
    in_ch.valid <= 0;
    stim_done = 1;

    while (pending != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    $display("covered %0d words, all thirteen commands plus unused codes,", words_sent);
    $display("divide by zero, signed overflow, random stalls and one long hold-off");
    if (errors == 0 && pending == 0)
      $display("[rv64m_multiply_divide_unit_core] OK");
    else
      $display("[rv64m_multiply_divide_unit_core] ERROR");
    $finish;
  end
endmodule

### sim.f
+incdir+design
design/mdu_pkg.sv
design/mdu_if.sv
design/mdu_cell.sv
design/mdu_front.sv
design/rv64m_multiply_divide_unit_core.sv
dv/mdu_checker.sv
dv/rv64m_multiply_divide_unit_core_test.sv
